>>> rtl/core/sha256_pkg.sv
`timescale 1ns / 1ps

package sha256_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned Rounds     = 64;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos     = 56;
  localparam int unsigned HashWords  = 8;
  localparam logic [7:0]  PadMark    = 8'h80;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_FINAL = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitHash [HashWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

>>> rtl/core/sha256_if.sv
`timescale 1ns / 1ps

interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        last_word;

  modport source (output valid, digest_word, word_number, last_word, input ready);
  modport sink (input valid, digest_word, word_number, last_word, output ready);
endinterface

>>> rtl/core/sha256_message_hasher.sv
// per block: each byte beat is taken while idle; the beat that fills a block is followed
//   by the compression rounds and then the hash update
// end of message: padding bytes are shifted in up to the block end, then one or two
//   compressions, then 8 digest beats, one per cycle when not stalled
// single shared round unit: no new byte is taken while a block is compressed, padded or output
// reset: synchronous active-low, loads the initial hash and clears count and length
`timescale 1ns / 1ps

module sha256_message_hasher (
  input  logic               clk,
  input  logic               rst_n,
  sha256_in_if.sink          in_chan,
  sha256_out_if.source       out_chan
);

  sha256_pkg::state_t state_r, state_nxt;
  logic [511:0]       msg_r, msg_nxt;
  logic [5:0]         fill_r, fill_nxt;
  logic [63:0]        bitlen_r, bitlen_nxt;
  logic [63:0]        len_r, len_nxt;
  logic [5:0]         round_r, round_nxt;
  logic [2:0]         wc_r, wc_nxt;
  sha256_pkg::word_t  hash_r [sha256_pkg::HashWords];
  sha256_pkg::word_t  hash_nxt [sha256_pkg::HashWords];
  sha256_pkg::word_t  work_r [sha256_pkg::HashWords];
  sha256_pkg::word_t  work_nxt [sha256_pkg::HashWords];
  logic               end_pend_r, end_pend_nxt;
  logic               mark_r, mark_nxt;
  logic               extra_r, extra_nxt;
  logic               final_r, final_nxt;

  logic               in_beat;
  logic               out_beat;
  logic               len_phase;
  logic [7:0]         pad_byte;
  sha256_pkg::word_t  w0, w1, w9, w14, new_w, t1, t2, ch, maj;

  assign in_chan.ready = (state_r == sha256_pkg::ST_IDLE);
  assign in_beat       = in_chan.valid & in_chan.ready;

  assign out_chan.valid       = (state_r == sha256_pkg::ST_OUT);
  assign out_chan.digest_word = hash_r[0];
  assign out_chan.word_number = wc_r;
  assign out_chan.last_word   = (wc_r == 3'd7);
  assign out_beat             = out_chan.valid & out_chan.ready;

  // schedule window lives in the message shift register, oldest word on top
  assign w0  = msg_r[511:480];
  assign w1  = msg_r[479:448];
  assign w9  = msg_r[223:192];
  assign w14 = msg_r[63:32];

  assign new_w = sha256_pkg::small_sig1(w14) + w9 + sha256_pkg::small_sig0(w1) + w0;
  assign ch    = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
  assign maj   = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
  assign t1    = work_r[7] + sha256_pkg::big_sig1(work_r[4]) + ch
               + sha256_pkg::RoundK[round_r] + w0;
  assign t2    = sha256_pkg::big_sig0(work_r[0]) + maj;

  assign len_phase = mark_r & ~extra_r & (fill_r >= 6'(sha256_pkg::LenPos));

  always_comb begin
    priority if (!mark_r) begin
      pad_byte = sha256_pkg::PadMark;
    end else if (len_phase) begin
      pad_byte = len_r[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    msg_nxt      = msg_r;
    fill_nxt     = fill_r;
    bitlen_nxt   = bitlen_r;
    len_nxt      = len_r;
    round_nxt    = round_r;
    wc_nxt       = wc_r;
    hash_nxt     = hash_r;
    work_nxt     = work_r;
    end_pend_nxt = end_pend_r;
    mark_nxt     = mark_r;
    extra_nxt    = extra_r;
    final_nxt    = final_r;

    unique case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (in_chan.byte_present) begin
            msg_nxt  = {msg_r[503:0], in_chan.msg_byte};
            fill_nxt = fill_r + 6'd1;
          end
          if (in_chan.byte_present && (fill_r == 6'(sha256_pkg::BlockBytes - 1))) begin
            bitlen_nxt   = bitlen_r + 64'd512;
            work_nxt     = hash_r;
            round_nxt    = '0;
            end_pend_nxt = in_chan.end_of_message;
            state_nxt    = sha256_pkg::ST_ROUND;
          end else if (in_chan.end_of_message) begin
            state_nxt = sha256_pkg::ST_PAD;
          end
        end
      end

      sha256_pkg::ST_ROUND: begin
        work_nxt[7] = work_r[6];
        work_nxt[6] = work_r[5];
        work_nxt[5] = work_r[4];
        work_nxt[4] = work_r[3] + t1;
        work_nxt[3] = work_r[2];
        work_nxt[2] = work_r[1];
        work_nxt[1] = work_r[0];
        work_nxt[0] = t1 + t2;
        msg_nxt     = {msg_r[479:0], new_w};
        round_nxt   = round_r + 6'd1;
        if (round_r == 6'(sha256_pkg::Rounds - 1)) begin
          state_nxt = sha256_pkg::ST_FINAL;
        end
      end

      sha256_pkg::ST_FINAL: begin
        for (int j = 0; j < sha256_pkg::HashWords; j++) begin
          hash_nxt[j] = hash_r[j] + work_r[j];
        end
        priority if (final_r) begin
          wc_nxt    = '0;
          state_nxt = sha256_pkg::ST_OUT;
        end else if (end_pend_r || mark_r) begin
          end_pend_nxt = 1'b0;
          state_nxt    = sha256_pkg::ST_PAD;
        end else begin
          state_nxt = sha256_pkg::ST_IDLE;
        end
      end

      sha256_pkg::ST_PAD: begin
        msg_nxt  = {msg_r[503:0], pad_byte};
        fill_nxt = fill_r + 6'd1;
        if (!mark_r) begin
          // data bytes never leave the low 9 bits of the length set
          mark_nxt  = 1'b1;
          extra_nxt = (fill_r >= 6'(sha256_pkg::LenPos));
          len_nxt   = {bitlen_r[63:9], fill_r, 3'b000};
        end
        if (len_phase) begin
          len_nxt = {len_r[55:0], 8'h00};
        end
        if (fill_r == 6'(sha256_pkg::BlockBytes - 1)) begin
          extra_nxt = 1'b0;
          final_nxt = len_phase;
          work_nxt  = hash_r;
          round_nxt = '0;
          state_nxt = sha256_pkg::ST_ROUND;
        end
      end

      sha256_pkg::ST_OUT: begin
        if (out_beat) begin
          // shift the digest out and refill with the initial values behind it
          for (int j = 0; j < sha256_pkg::HashWords - 1; j++) begin
            hash_nxt[j] = hash_r[j + 1];
          end
          hash_nxt[sha256_pkg::HashWords - 1] = sha256_pkg::InitHash[wc_r];
          wc_nxt = wc_r + 3'd1;
          if (wc_r == 3'd7) begin
            bitlen_nxt = '0;
            mark_nxt   = 1'b0;
            final_nxt  = 1'b0;
            state_nxt  = sha256_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = sha256_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sha256_pkg::ST_IDLE;
      fill_r     <= '0;
      bitlen_r   <= '0;
      round_r    <= '0;
      wc_r       <= '0;
      hash_r     <= sha256_pkg::InitHash;
      end_pend_r <= 1'b0;
      mark_r     <= 1'b0;
      extra_r    <= 1'b0;
      final_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      bitlen_r   <= bitlen_nxt;
      round_r    <= round_nxt;
      wc_r       <= wc_nxt;
      hash_r     <= hash_nxt;
      end_pend_r <= end_pend_nxt;
      mark_r     <= mark_nxt;
      extra_r    <= extra_nxt;
      final_r    <= final_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msg_r  <= msg_nxt;
    len_r  <= len_nxt;
    work_r <= work_nxt;
  end

endmodule

>>> rtl/core/sha256_checker.sv
`timescale 1ns / 1ps

module sha256_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_end_of_message,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_number,
  input logic        out_last_word
);

  logic in_beat;
  logic out_beat;

  assign in_beat  = in_valid & in_ready;
  assign out_beat = out_valid & out_ready;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
                                && $stable(out_word_number))
    else $error("digest beat changed while stalled");

  a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while digest is out");

  a_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && !out_last_word |=> out_valid
                                   && out_word_number == 3'($past(out_word_number) + 3'd1))
    else $error("digest words not consecutive");

  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_end_of_message |=> !in_ready)
    else $error("ready right after end of message");

  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && out_last_word |=> in_ready && !out_valid)
    else $error("not idle after last digest word");

endmodule

bind sha256_message_hasher sha256_checker u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .in_end_of_message (in_chan.end_of_message),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_digest_word   (out_chan.digest_word),
  .out_word_number   (out_chan.word_number),
  .out_last_word     (out_chan.last_word)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned ItemGoal   = 260;

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] StartChain [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    sha256_pkg::word_t digest_word;
    logic [2:0]        word_number;
    logic              last_word;
  } digest_beat_t;

  class sha256_scoreboard;
    logic [31:0]  chain [8];
    logic [7:0]   blk [64];
    int unsigned  fill;
    logic [63:0]  bit_len;
    digest_beat_t digest_queue [$];
    int unsigned  errors;
    int unsigned  messages;
    int unsigned  words_checked;

    function void restart_chain();
      for (int j = 0; j < 8; j++) chain[j] = StartChain[j];
      fill = 0;
      bit_len = '0;
    endfunction

    function logic [31:0] ror32(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] wr, t1, t2, s0, s1;
      for (int j = 0; j < 16; j++) w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
      for (int j = 0; j < 8; j++) v[j] = chain[j];
      for (int r = 0; r < 64; r++) begin
        if (r < 16) begin
          wr = w[r];
        end else begin
          s0 = ror32(w[(r-15) & 15], 7) ^ ror32(w[(r-15) & 15], 18) ^ (w[(r-15) & 15] >> 3);
          s1 = ror32(w[(r-2) & 15], 17) ^ ror32(w[(r-2) & 15], 19) ^ (w[(r-2) & 15] >> 10);
          wr = s1 + w[(r-7) & 15] + s0 + w[r & 15];
          w[r & 15] = wr;
        end
        t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + wr;
        t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) chain[j] = chain[j] + v[j];
    endfunction

    function void note_beat(logic [7:0] data, logic present, logic eom);
      int unsigned i;
      logic [63:0] total;
      if (present) begin
        blk[fill] = data;
        fill++;
        if (fill == 64) begin
          compress();
          fill = 0;
          bit_len = bit_len + 64'd512;
        end
      end
      if (!eom) return;
      i = fill;
      total = bit_len + (64'(fill) << 3);
      blk[i] = 8'h80;
      i++;
      // no room for the length field, so padding spills into a second block
      if (i > 56) begin
        while (i < 64) begin
          blk[i] = 8'h00;
          i++;
        end
        compress();
        i = 0;
      end
      while (i < 56) begin
        blk[i] = 8'h00;
        i++;
      end
      for (int j = 0; j < 8; j++) blk[56+j] = total[63-8*j -: 8];
      compress();
      for (int j = 0; j < 8; j++) digest_queue.push_back('{chain[j], 3'(j), j == 7});
      messages++;
      restart_chain();
    endfunction

    function void check_digest(sha256_pkg::word_t word, logic [2:0] num, logic fin);
      digest_beat_t exp_beat;
      if (digest_queue.size() == 0) begin
        $error("digest beat with nothing pending: word %h number %0d", word, num);
        errors++;
        return;
      end
      exp_beat = digest_queue.pop_front();
      words_checked++;
      if (word !== exp_beat.digest_word) begin
        $error("digest_word: expected %h, got %h", exp_beat.digest_word, word);
        errors++;
      end
      if (num !== exp_beat.word_number) begin
        $error("word_number: expected %0d, got %0d", exp_beat.word_number, num);
        errors++;
      end
      if (fin !== exp_beat.last_word) begin
        $error("last_word: expected %0b, got %0b", exp_beat.last_word, fin);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sha256_in_if  in_chan ();
  sha256_out_if out_chan ();

  sha256_message_hasher DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sha256_scoreboard sb;
  logic        no_gaps;
  int unsigned holds_asked;
  int unsigned holds_done;
  int unsigned items_sent;
  int unsigned stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_beat(input logic [7:0] data, input logic present, input logic eom);
    if (!no_gaps && $urandom_range(99) < 13) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.msg_byte       <= data;
    in_chan.byte_present   <= present;
    in_chan.end_of_message <= eom;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_beat(data, present, eom);
    if (present || eom) items_sent++;
  endtask

  // random bytes with stray empty beats; the end mark rides on the last byte or on
  // an empty closing beat
  task automatic send_message(input int unsigned len, input logic mark_on_byte);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(99) < 8) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, mark_on_byte && (k == len - 1));
    end
    if (!mark_on_byte || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    while (sb.digest_queue.size() != 0) @(posedge clk);
  endtask

  initial begin : digest_sink
    logic take;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (holds_asked != holds_done) begin
        holds_done++;
        out_chan.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      take = no_gaps || ($urandom_range(99) >= 13);
      out_chan.ready <= take;
      @(posedge clk);
      if (take && out_chan.valid) begin
        sb.check_digest(out_chan.digest_word, out_chan.word_number, out_chan.last_word);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned msg_idx;
    int unsigned len;
    sb = new;
    sb.restart_chain();
    no_gaps = 1'b0;
    holds_asked = 0;
    items_sent = 0;
    rst_n                  <= 1'b0;
    in_chan.valid          <= 1'b0;
    in_chan.msg_byte       <= 8'h00;
    in_chan.byte_present   <= 1'b0;
    in_chan.end_of_message <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone empty beat, then the empty message
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    // single byte carrying the end mark, both byte extremes
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    // bytes, an empty beat, then an empty closing beat
    send_beat(8'ha5, 1'b1, 1'b0);
    send_beat(8'h5a, 1'b1, 1'b0);
    send_beat(8'h3c, 1'b0, 1'b0);
    send_beat(8'hc3, 1'b0, 1'b1);
    in_chan.valid <= 1'b0;
    wait_drained();

    // receiver stalls long enough for the hasher to back up into its input
    holds_asked++;
    send_message($urandom_range(1, 8), 1'b1);
    send_message($urandom_range(0, 8), 1'b0);

    msg_idx = 0;
    while (items_sent < ItemGoal || msg_idx < 8) begin
      no_gaps = (msg_idx >= 3 && msg_idx < 6);
      case ($urandom_range(9))
        0, 1, 2, 3: len = $urandom_range(0, 12);
        4, 5, 6: begin
          // lengths around the padding and block boundaries
          case ($urandom_range(7))
            0: len = 54;
            1: len = 55;
            2: len = 56;
            3: len = 57;
            4: len = 63;
            5: len = 64;
            6: len = 65;
            default: len = 128;
          endcase
        end
        default: len = $urandom_range(1, 40);
      endcase
      // keep the gap-free stretch long
      if (no_gaps && len < 24) len = 24;
      send_message(len, 1'($urandom_range(1)));
      msg_idx++;
    end
    no_gaps = 1'b0;
    in_chan.valid <= 1'b0;

    wait_drained();
    repeat (200) @(posedge clk);
    $display("hashed %0d messages from %0d input items, checked %0d digest words",
             sb.messages, items_sent, sb.words_checked);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
